[rtl/count_sorted_record_store_defines.svh]
// Assertion macros for the count-sorted record store.
// Included by modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef COUNT_SORTED_RECORD_STORE_DEFINES_SVH
`define COUNT_SORTED_RECORD_STORE_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define CSRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check a property on every clock edge, reset included
`define CSRS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSRS_ASSERT(lbl, prop, msg)
`define CSRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/csrs_pkg.sv]
// Shared types and sizes for the count-sorted record store.
// No dependencies; used by csrs_cell and count_sorted_record_store.
package csrs_pkg;

	localparam int CAPACITY = 16;
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 32;
	localparam int TAG_W    = 20;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	localparam logic ST_RECORD = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] cnt;
		logic [TAG_W-1:0]   tag;
	} record_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

[rtl/csrs_cell.sv]
// One cell of the sorting chain: holds one record, opens a gap on insert,
// and passes its record toward the head on drain. Depends on csrs_pkg.
module csrs_cell (
	input  logic               clk,
	input  csrs_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  csrs_pkg::record_t  new_rec,
	input  logic               left_take,
	input  csrs_pkg::record_t  left_rec,
	input  csrs_pkg::record_t  right_rec,
	output logic               take,
	output csrs_pkg::record_t  rec
);
	import csrs_pkg::*;

	record_t rec_q;

	// claim the new record if this slot is free or holds a larger count
	assign take = !occ || (rec_q.cnt > new_rec.cnt);
	assign rec  = rec_q;

	// load new record at the insert point, take the left record behind it,
	// advance toward the head on drain
	always_ff @(posedge clk) begin
		if (ctl.ins && take) begin
			rec_q <= left_take ? left_rec : new_rec;
		end else if (ctl.shift) begin
			rec_q <= right_rec;
		end
	end

endmodule

[rtl/count_sorted_record_store.sv]
// Top level of the count-sorted record store: chain of sorting cells,
// fill counter, drain sequencer and result register. Depends on csrs_pkg,
// csrs_cell and count_sorted_record_store_defines.svh.

// Keeps up to CAPACITY (count, tag) records in ascending count order; equal
// counts keep arrival order. A request is taken when start is high and busy
// is low. The next request may follow an insert at once; every cell
// compares the new count in parallel and the chain shifts in the same
// cycle. An insert into a full store returns the record in the next cycle
// with status 1 and last_of_run 1. A drain raises busy until the store is
// empty and emits one record per cycle on result_valid from the head cell
// through the result register, shifting the chain toward its head; the
// final record carries last_of_run. Results are shown for exactly one
// cycle and cannot be held off, so the receiver must take every strobe.
// A drain of an empty store returns nothing.
`include "count_sorted_record_store_defines.svh"
module count_sorted_record_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [csrs_pkg::COUNT_W-1:0]  key_count,
	input  logic [csrs_pkg::TAG_W-1:0]    word_tag,
	output logic                          result_valid,
	output logic                          status,
	output logic [csrs_pkg::COUNT_W-1:0]  out_count,
	output logic [csrs_pkg::TAG_W-1:0]    out_tag,
	output logic                          last_of_run
);
	import csrs_pkg::*;

	logic [FILL_W-1:0] fill_q;
	logic              draining_q;
	logic              result_valid_q;
	logic              status_q;
	logic              last_q;
	record_t           out_rec_q;

	logic      accept;
	logic      full;
	logic      do_insert;
	logic      do_reject;
	logic      do_drain;
	cell_ctl_t ctl;
	record_t   new_rec;

	logic    [CAPACITY-1:0] occ;
	logic    [CAPACITY-1:0] take;
	record_t                rec [CAPACITY];

	// decode the request
	assign accept    = start && !draining_q;
	assign full      = (fill_q == FILL_W'(CAPACITY));
	assign do_insert = accept && (opcode == OP_INSERT) && !full;
	assign do_reject = accept && (opcode == OP_INSERT) && full;
	assign do_drain  = accept && (opcode == OP_DRAIN) && (fill_q != '0);

	assign new_rec.cnt = key_count;
	assign new_rec.tag = word_tag;
	assign ctl.ins     = do_insert;
	assign ctl.shift   = draining_q;

	// build the chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic    lt;
		record_t lr;
		record_t rr;

		assign occ[i] = (fill_q > FILL_W'(i));

		if (i == 0) begin : g_head
			assign lt = 1'b0;
			assign lr = new_rec;
		end else begin : g_body
			assign lt = take[i-1];
			assign lr = rec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rr = rec[i];
		end else begin : g_inner
			assign rr = rec[i+1];
		end

		csrs_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ[i]),
			.new_rec   (new_rec),
			.left_take (lt),
			.left_rec  (lr),
			.right_rec (rr),
			.take      (take[i]),
			.rec       (rec[i])
		);
	end

	// track occupancy and the drain run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			draining_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= do_reject || draining_q;
			if (do_insert) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (draining_q) begin
				fill_q <= fill_q - FILL_W'(1);
				if (fill_q == FILL_W'(1)) begin
					draining_q <= 1'b0;
				end
			end
			if (do_drain) begin
				draining_q <= 1'b1;
			end
		end
	end

	// register the result payload
	always_ff @(posedge clk) begin
		if (draining_q) begin
			out_rec_q <= rec[0];
			status_q  <= ST_RECORD;
			last_q    <= (fill_q == FILL_W'(1));
		end else if (do_reject) begin
			out_rec_q <= new_rec;
			status_q  <= ST_REJECT;
			last_q    <= 1'b1;
		end
	end

	assign busy         = draining_q;
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign out_count    = out_rec_q.cnt;
	assign out_tag      = out_rec_q.tag;
	assign last_of_run  = last_q;

	// checks
	`CSRS_ASSERT(a_drain_nonempty, draining_q |-> (fill_q != '0), "drain running on empty store")
	`CSRS_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(CAPACITY), "fill count beyond capacity")
	`CSRS_ASSERT(a_reject_full, (result_valid_q && status_q == ST_REJECT) |-> $past(full), "reject while not full")
	`CSRS_ASSERT(a_drain_order, (result_valid_q && status_q == ST_RECORD && !last_q) |=> (result_valid_q && out_rec_q.cnt >= $past(out_rec_q.cnt)), "drain out of order")

endmodule

[tb/count_sorted_record_store_checker.sv]
// Scoreboard for the count-sorted record store: mirrors the sorted store,
// queues the expected outputs and compares each result strobe in order.
// Depends on csrs_pkg for field widths, opcodes and status codes.
module count_sorted_record_store_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         opcode,
	input  logic [csrs_pkg::COUNT_W-1:0] key_count,
	input  logic [csrs_pkg::TAG_W-1:0]   word_tag,
	input  logic                         result_valid,
	input  logic                         status,
	input  logic [csrs_pkg::COUNT_W-1:0] out_count,
	input  logic [csrs_pkg::TAG_W-1:0]   out_tag,
	input  logic                         last_of_run,
	output int                           errors,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import csrs_pkg::*;

	typedef struct {
		logic               status;
		logic [COUNT_W-1:0] cnt;
		logic [TAG_W-1:0]   tag;
		logic               last;
	} out_rec_t;

	// mirror of the sorted store, ascending by count
	logic [COUNT_W-1:0] sorted_cnt [CAPACITY];
	logic [TAG_W-1:0]   sorted_tag [CAPACITY];
	int                 held = 0;
	out_rec_t           due_records[$];
	int                 mismatches = 0;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	task automatic queue_record(input logic st, input logic [COUNT_W-1:0] c,
			input logic [TAG_W-1:0] t, input logic last);
		out_rec_t r;
		r.status = st;
		r.cnt    = c;
		r.tag    = t;
		r.last   = last;
		due_records.push_back(r);
	endtask

	// apply one accepted request to the mirror and queue what it gives out
	task automatic apply_request(input logic op, input logic [COUNT_W-1:0] k,
			input logic [TAG_W-1:0] t);
		int pos;
		int i;
		if (op == OP_INSERT) begin
			if (held >= CAPACITY) begin
				queue_record(ST_REJECT, k, t, 1'b1);
			end else begin
				// land after every count <= k so ties keep arrival order
				pos = 0;
				while (pos < held && sorted_cnt[pos] <= k)
					pos++;
				for (i = held; i > pos; i--) begin
					sorted_cnt[i] = sorted_cnt[i-1];
					sorted_tag[i] = sorted_tag[i-1];
				end
				sorted_cnt[pos] = k;
				sorted_tag[pos] = t;
				held++;
			end
		end else begin
			for (i = 0; i < held; i++)
				queue_record(ST_RECORD, sorted_cnt[i], sorted_tag[i], i == held - 1);
			held = 0;
		end
	endtask

	task automatic check_result();
		out_rec_t exp_rec;
		if (due_records.size() == 0) begin
			report_mismatch($sformatf("unexpected result st=%0b cnt=%h tag=%h last=%0b",
				status, out_count, out_tag, last_of_run));
		end else begin
			exp_rec = due_records.pop_front();
			if (status !== exp_rec.status || out_count !== exp_rec.cnt ||
					out_tag !== exp_rec.tag || last_of_run !== exp_rec.last)
				report_mismatch($sformatf(
					"got st=%0b cnt=%h tag=%h last=%0b, want st=%0b cnt=%h tag=%h last=%0b",
					status, out_count, out_tag, last_of_run,
					exp_rec.status, exp_rec.cnt, exp_rec.tag, exp_rec.last));
		end
	endtask

	// compare results from earlier requests, then take this edge's request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			due_records.delete();
			pending <= 0;
			errors  <= mismatches;
		end else begin
			if (result_valid)
				check_result();
			if (start && !busy)
				apply_request(opcode, key_count, word_tag);
			pending <= due_records.size();
			errors  <= mismatches;
		end
	end

endmodule

[tb/tb.sv]
// Testbench top for the count-sorted record store: clock, reset, request
// stimulus, watchdog and verdict. Depends on csrs_pkg, the store RTL and
// count_sorted_record_store_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csrs_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [COUNT_W-1:0] key_count;
	logic [TAG_W-1:0]   word_tag;
	logic               result_valid;
	logic               status;
	logic [COUNT_W-1:0] out_count;
	logic [TAG_W-1:0]   out_tag;
	logic               last_of_run;
	int                 errors;
	int                 pending;
	int                 sent;
	int                 sender_idle_pct;
	int                 stall_cycles;

	count_sorted_record_store i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.key_count    (key_count),
		.word_tag     (word_tag),
		.result_valid (result_valid),
		.status       (status),
		.out_count    (out_count),
		.out_tag      (out_tag),
		.last_of_run  (last_of_run)
	);

	count_sorted_record_store_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.key_count    (key_count),
		.word_tag     (word_tag),
		.result_valid (result_valid),
		.status       (status),
		.out_count    (out_count),
		.out_tag      (out_tag),
		.last_of_run  (last_of_run),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((start && !busy) || result_valid)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("[count_sorted_record_store] ERROR");
				$finish;
			end
		end
	end

	// hold the request until the store takes it
	task automatic issue(input logic op, input logic [COUNT_W-1:0] k,
			input logic [TAG_W-1:0] t);
		start     <= 1'b1;
		opcode    <= op;
		key_count <= k;
		word_tag  <= t;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	// drop start for single cycles at the chosen idle share
	task automatic maybe_idle();
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off until every queued result has come out
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// favor small counts for ties, with full-range and extreme values mixed in
	function automatic logic [COUNT_W-1:0] pick_count();
		logic [COUNT_W-1:0] k;
		case ($urandom_range(0, 5))
			0: k = $urandom_range(0, 3);
			1: k = $urandom_range(0, 15);
			2: k = $urandom;
			3: k = '0;
			4: k = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: k = $urandom_range(0, 255) << 24;
		endcase
		return k;
	endfunction

	initial begin
		int phase;
		int n;
		arst_n          = 1'b0;
		start           = 1'b0;
		opcode          = OP_INSERT;
		key_count       = '0;
		word_tag        = '0;
		sent            = 0;
		sender_idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drain an empty store: nothing comes back
		issue(OP_DRAIN, 32'hFFFF_FFFF, 20'hFFFFF);
		// extremes and a run of equal counts
		issue(OP_INSERT, 32'hFFFF_FFFF, 20'h00000);
		issue(OP_INSERT, 32'h0000_0000, 20'hFFFFF);
		issue(OP_INSERT, 32'd7, 20'h0000A);
		issue(OP_INSERT, 32'd7, 20'h0000B);
		issue(OP_INSERT, 32'd7, 20'h0000C);
		issue(OP_INSERT, 32'h0000_0000, 20'h00001);
		// fill to capacity, then insert into the full store twice
		repeat (CAPACITY - 6)
			issue(OP_INSERT, $urandom_range(0, 8), TAG_W'($urandom_range(0, 20'hFFFFF)));
		issue(OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF);
		issue(OP_INSERT, 32'h0000_0000, 20'h00000);
		issue(OP_DRAIN, 32'h0000_0000, 20'h00000);
		settle();

		// random insert bursts closed by a drain, some single random requests
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: sender_idle_pct = 33;
				1: sender_idle_pct = 45;
				default: sender_idle_pct = 0;
			endcase
			while (sent < 20 + 100 * (phase + 1)) begin
				if ($urandom_range(0, 9) != 0) begin
					if ($urandom_range(0, 3) == 0)
						n = $urandom_range(CAPACITY - 2, CAPACITY + 4);
					else
						n = $urandom_range(1, CAPACITY);
					repeat (n) begin
						maybe_idle();
						issue(OP_INSERT, pick_count(),
							TAG_W'($urandom_range(0, 20'hFFFFF)));
					end
					maybe_idle();
					issue(OP_DRAIN, $urandom, TAG_W'($urandom_range(0, 20'hFFFFF)));
				end else begin
					maybe_idle();
					issue(1'($urandom_range(0, 1)), pick_count(),
						TAG_W'($urandom_range(0, 20'hFFFFF)));
				end
			end
			settle();
		end

		// empty the store so every record is checked
		issue(OP_DRAIN, '0, '0);
		settle();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[count_sorted_record_store] OK");
		else
			$display("[count_sorted_record_store] ERROR");
		$finish;
	end

endmodule
